// ===== sv/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg: shared types, constants and angle table
// Payload structs, the CORDIC arctangent table and formats for the
// rotation matrix to Euler angle block.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int ELEM_W      = 16;
    localparam int ANG_W       = 16;
    localparam int LIMIT_W     = 15;
    localparam int SUM_W       = 32;
    localparam int ROOT_W      = 16;
    localparam int CORDIC_W    = 40;
    localparam int Z_W         = 34;
    localparam int MAX_STAGES  = 24;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int ADDR_W      = 3;

    localparam logic [ADDR_W-1:0] REG_SINGULAR_LIMIT = 3'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1;

    localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_MAX = 16'sd25736;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_00;
        logic signed [ELEM_W-1:0] elem_10;
        logic signed [ELEM_W-1:0] elem_20;
        logic signed [ELEM_W-1:0] elem_21;
        logic signed [ELEM_W-1:0] elem_22;
        logic signed [ELEM_W-1:0] elem_11;
        logic signed [ELEM_W-1:0] elem_12;
    } in_item_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll_angle;
        logic signed [ANG_W-1:0] pitch_angle;
        logic signed [ANG_W-1:0] yaw_angle;
        logic                    singular_flag;
    } out_item_t;

    // One CORDIC lane: vector, angle accumulator, zero-input mark
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [Z_W-1:0]      z;
        logic                       zero;
    } lane_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        v = '0;
        case (i)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Prepare a lane: fold the left half plane, scale to CORDIC units
    function automatic lane_t lane_init(input logic signed [ROOT_W+1:0] y,
                                        input logic signed [ROOT_W+1:0] x);
        lane_t l;
        logic signed [CORDIC_W-1:0] xe;
        logic signed [CORDIC_W-1:0] ye;
        xe = CORDIC_W'(x);
        ye = CORDIC_W'(y);
        l.zero = (x == '0) && (y == '0);
        l.z = '0;
        if (x < 0)
        begin
            l.z = (y >= 0) ? PI_Q30 : -PI_Q30;
            xe = -xe;
            ye = -ye;
        end
        l.x = xe <<< 14;
        l.y = ye <<< 14;
        return l;
    endfunction

    // Round Q4.30 angle to Q3.13 with saturation
    function automatic logic signed [ANG_W-1:0] lane_angle(input lane_t l);
        logic signed [Z_W-1:0] r;
        logic signed [ANG_W-1:0] a;
        r = (l.z + Z_W'(65536)) >>> 17;
        if (l.zero)
            a = '0;
        else if (r > Z_W'(ANG_MAX))
            a = ANG_MAX;
        else if (r < -Z_W'(ANG_MAX))
            a = -ANG_MAX;
        else
            a = r[ANG_W-1:0];
        return a;
    endfunction

endpackage

// ===== sv/rme_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// rme_sqrt_stage: one step of a pipelined integer square root
// Settles one result bit per stage by restoring subtraction.
// ----------------------------------------------------------------------------
module rme_sqrt_stage #(
    parameter int BIT = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rme_pkg::SUM_W-1:0]  rem_in,
    input  logic [rme_pkg::SUM_W-1:0]  res_in,
    output logic [rme_pkg::SUM_W-1:0]  rem_out,
    output logic [rme_pkg::SUM_W-1:0]  res_out
);
    import rme_pkg::*;

    localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << (2 * BIT);

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] res_reg, res_next;
    logic [SUM_W-1:0] trial;

    // Try the bit, keep it when the remainder allows
    always_comb
    begin
        trial = res_in + ONE;
        if (rem_in >= trial)
        begin
            rem_next = rem_in - trial;
            res_next = (res_in >> 1) + ONE;
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;
endmodule

// ===== sv/rme_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// rme_cordic_stage: one vectoring CORDIC micro-rotation
// Rotates the vector toward the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module rme_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic             clk,
    input  logic             en,
    input  rme_pkg::lane_t   lane_in,
    output rme_pkg::lane_t   lane_out
);
    import rme_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_entry(5'(SHIFT));

    lane_t lane_reg, lane_next;
    logic signed [CORDIC_W-1:0] xs, ys;

    // Rotate by the sign of y
    always_comb
    begin
        xs = lane_in.x >>> SHIFT;
        ys = lane_in.y >>> SHIFT;
        lane_next = lane_in;
        if (lane_in.y >= 0)
        begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + ATAN;
        end
        else
        begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;
endmodule

// ===== sv/rotation_matrix_to_euler.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler: ZYX Euler angles from a rotation matrix
// Streams one matrix item per cycle through square root and CORDIC stages.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_item): seven Q2.14 matrix elements.
//   out channel (out_valid/out_ready/out_item): roll, pitch, yaw in Q3.13
//   and the gimbal-lock flag. One result per item, in order.
//   APB port: register 0 at address 0 is singular_limit (15 bits).
// Pipeline: capture register, sum of squares, 16 square root steps, lane
//   setup, the CORDIC stages and rounding; the accepting edge itself
//   loads the capture register.
// Throughput: one item per cycle; every stage is one register step.
// Reset clears all valid bits and sets singular_limit to 1.
// When the receiver stalls, the whole pipeline holds; in_ready is low only
// while the output register is full and not taken.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler #(
    parameter int CORDIC_STAGES = rme_pkg::DEF_CORDIC_STAGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rme_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rme_pkg::out_item_t            out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rme_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rme_pkg::*;

    localparam int SQ = ROOT_W;
    localparam int DEPTH = 2 + SQ + 1 + CORDIC_STAGES + 1;
    localparam int SI = 1 + SQ;

    // Side data carried down to the lane setup stage
    typedef struct packed {
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
    } side_t;

    logic [LIMIT_W-1:0] limit_reg;
    logic en;
    logic [DEPTH-1:0] vld_reg;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && paddr == REG_SINGULAR_LIMIT)
            limit_reg <= pwdata[LIMIT_W-1:0];
    end
    assign prdata = (paddr == REG_SINGULAR_LIMIT) ? 32'(limit_reg) : '0;

    // Global stall: advance when the output can take a new item
    assign en = !out_valid || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // Stage 0: capture; stage 1: squares and sum
    in_item_t in_reg;
    side_t side_reg [SI+1];
    logic [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sq00, sq10;

    always_comb
    begin
        sq00 = in_reg.elem_00 * in_reg.elem_00;
        sq10 = in_reg.elem_10 * in_reg.elem_10;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= in_item;
            side_reg[0] <= '{in_item.elem_20, in_item.elem_10, in_item.elem_00,
                             in_item.elem_21, in_item.elem_22, in_item.elem_11,
                             in_item.elem_12};
            sum_reg <= SUM_W'(sq00) + SUM_W'(sq10);
        end
    end

    // Carry side data down to the lane setup stage
    genvar g;
    generate
        for (g = 1; g < SI + 1; g++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[g] <= side_reg[g-1];
            end
        end
    endgenerate

    // Square root: one result bit per stage, top bit first
    logic [SUM_W-1:0] rem_w [SQ+1];
    logic [SUM_W-1:0] res_w [SQ+1];
    assign rem_w[0] = sum_reg;
    assign res_w[0] = '0;
    generate
        for (g = 0; g < SQ; g++)
        begin : g_sqrt
            rme_sqrt_stage #(.BIT(SQ - 1 - g)) u_sqrt (
                .clk(clk), .en(en),
                .rem_in(rem_w[g]), .res_in(res_w[g]),
                .rem_out(rem_w[g+1]), .res_out(res_w[g+1])
            );
        end
    endgenerate

    // Lane setup: pick branch, fold operands
    side_t sd;
    logic [ROOT_W-1:0] sy;
    logic sing;
    lane_t lane_w [3][CORDIC_STAGES+1];
    lane_t l0_reg, l1_reg, l2_reg;
    logic sing_reg [CORDIC_STAGES+1];

    assign sd = side_reg[SI];
    assign sy = res_w[SQ][ROOT_W-1:0];
    assign sing = {1'b0, sy} < {1'b0, limit_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l0_reg <= lane_init(-(ROOT_W+2)'(sd.m20), (ROOT_W+2)'({1'b0, sy}));
            if (sing)
                l1_reg <= lane_init(-(ROOT_W+2)'(sd.m12), (ROOT_W+2)'(sd.m11));
            else
                l1_reg <= lane_init((ROOT_W+2)'(sd.m21), (ROOT_W+2)'(sd.m22));
            l2_reg <= lane_init((ROOT_W+2)'(sd.m10), (ROOT_W+2)'(sd.m00));
            sing_reg[0] <= sing;
        end
    end

    generate
        for (g = 1; g < CORDIC_STAGES + 1; g++)
        begin : g_flag
            always_ff @(posedge clk)
            begin
                if (en)
                    sing_reg[g] <= sing_reg[g-1];
            end
        end
    endgenerate

    assign lane_w[0][0] = l0_reg;
    assign lane_w[1][0] = l1_reg;
    assign lane_w[2][0] = l2_reg;

    // Three CORDIC lanes: pitch, roll, yaw
    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_lane
            for (g = 0; g < CORDIC_STAGES; g++)
            begin : g_rot
                rme_cordic_stage #(.SHIFT(g)) u_rot (
                    .clk(clk), .en(en),
                    .lane_in(lane_w[k][g]), .lane_out(lane_w[k][g+1])
                );
            end
        end
    endgenerate

    // Round, saturate and register the result
    out_item_t out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.pitch_angle   <= lane_angle(lane_w[0][CORDIC_STAGES]);
            out_reg.roll_angle    <= lane_angle(lane_w[1][CORDIC_STAGES]);
            out_reg.yaw_angle     <= sing_reg[CORDIC_STAGES] ? '0
                                     : lane_angle(lane_w[2][CORDIC_STAGES]);
            out_reg.singular_flag <= sing_reg[CORDIC_STAGES];
        end
    end
    assign out_item = out_reg;

    // A stall must hold the result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed under stall");
    // A singular result has zero yaw
    a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.singular_flag |-> out_item.yaw_angle == '0)
        else $error("singular result with nonzero yaw");
    // Ready follows the output register
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule
